// File: rtl/core/lpsfg_pkg.sv
// Shared types and constants for the LED PWM shift-frame generator.
// Used by every module of the block; depends on nothing else.
package lpsfg_pkg;

    // Default LED count, and the width of a byte of channel bits.
    localparam int NUM_LEDS_DEF = 16;
    localparam int BYTE_BITS    = 8;

    // Item kinds.
    localparam logic [1:0] KIND_RGB  = 2'd0;
    localparam logic [1:0] KIND_HSV  = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    // Configuration port.
    localparam int          PADDR_W       = 3;
    localparam logic        REG_PWM_MAX   = 1'b0;
    localparam logic [7:0]  PWM_MAX_RESET = 8'd255;

    // HSV conversion constants.
    localparam logic [7:0]  FULL_SCALE  = 8'd255;
    localparam int          SECTOR_DEG  = 60;
    localparam int          LAST_SECTOR = 5;
    // floor(h/60) = (h*547)>>15 holds exactly for every 9-bit hue.
    localparam int          HUE_RECIP   = 547;
    // floor(p/60) = (p*17477)>>20 holds exactly for p up to 255*60.
    localparam int          DIV60_RECIP = 17477;

    // Depth of the queue between the front and the back.
    localparam int          QUEUE_DEPTH = 2;

    // One input word.
    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [8:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
    } t_in_item;

    // One output word.
    typedef struct packed {
        logic [7:0] shift_byte;
        logic       latch_last;
    } t_out_word;

    // A classified operation handed from the front to the back.
    typedef struct packed {
        logic       is_tick;
        logic [3:0] led;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_op;

endpackage

// File: rtl/core/led_pwm_shift_frame_generator.sv
// LED PWM shift-frame generator, top level: configuration register,
// front end, operation queue and back end. Depends on lpsfg_pkg.
//
// Input channel (i_valid, i_item, o_stall): one word per RGB write, HSV
// write or PWM tick. Writes to an LED beyond NUM_LEDS and unused kinds are
// dropped. The front takes no new word until it is through with the last:
// RGB writes and ticks go straight to the push, while HSV writes first step
// through a short multiply chain. Output channel (o_valid, o_word, i_stall):
// a tick yields floor(3*NUM_LEDS/8) words, the last with latch_last set.
// Each row is read from the eight duty banks into a register and compared,
// and the next read starts only once its byte can enter the output register.
// A write is taken while the back stays idle; a tick holds the back in its
// streaming state until the last row is read. When the receiver stalls, the
// output register holds its word and the back waits; the queue lets the front
// keep taking words meanwhile. After reset the duty store is cleared one row
// per cycle, all ceil(3*NUM_LEDS/8) rows, during which o_stall is high.
// pwm_max is written through the APB port at address 0 and resets to 255.
module led_pwm_shift_frame_generator #(
    parameter int NUM_LEDS = lpsfg_pkg::NUM_LEDS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  lpsfg_pkg::t_in_item               i_item,
    output logic                              o_stall,
    output logic                              o_valid,
    output lpsfg_pkg::t_out_word              o_word,
    input  logic                              i_stall,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lpsfg_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import lpsfg_pkg::*;

    logic [7:0] r_pwm_max;
    logic       w_clearing;
    logic       q_push, q_pop, q_full, q_empty;
    t_op        q_in, q_head;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PWM_MAX) ? {24'b0, r_pwm_max} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_max <= PWM_MAX_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_PWM_MAX) begin
            r_pwm_max <= pwdata[7:0];
        end
    end

    // Front end.
    lpsfg_front #(
        .NUM_LEDS(NUM_LEDS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_item     (i_item),
        .o_stall    (o_stall),
        .i_clearing (w_clearing),
        .o_push     (q_push),
        .o_op       (q_in),
        .i_full     (q_full)
    );

    // Operation queue.
    lpsfg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back end.
    lpsfg_back #(
        .NUM_LEDS(NUM_LEDS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (q_head),
        .i_empty    (q_empty),
        .o_pop      (q_pop),
        .i_pwm_max  (r_pwm_max),
        .o_clearing (w_clearing),
        .o_valid    (o_valid),
        .o_word     (o_word),
        .i_stall    (i_stall)
    );

`ifndef SYNTHESIS
    // Every reset starts the clear pass of the duty store.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> w_clearing)
        else $error("clear pass did not start after reset");

    // No input word is taken while the duty store is being cleared.
    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> o_stall)
        else $error("input taken during clear pass");

    // No output word is offered while the duty store is being cleared.
    a_clear_no_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !o_valid)
        else $error("output word during clear pass");
`endif

endmodule

// File: rtl/core/lpsfg_front.sv
// Front end: accepts input words, drops the ones that change nothing, and
// converts HSV writes to RGB over a few steps. Depends on lpsfg_pkg.
module lpsfg_front #(
    parameter int NUM_LEDS = lpsfg_pkg::NUM_LEDS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  lpsfg_pkg::t_in_item i_item,
    output logic                o_stall,
    input  logic                i_clearing,
    output logic                o_push,
    output lpsfg_pkg::t_op      o_op,
    input  logic                i_full
);
    import lpsfg_pkg::*;

    typedef enum logic [5:0] {
        F_IDLE = 6'b000001,
        F_MUL1 = 6'b000010,
        F_FRAC = 6'b000100,
        F_MUL2 = 6'b001000,
        F_DIV  = 6'b010000,
        F_PUSH = 6'b100000
    } t_front_state;

    t_front_state r_state, n_state;
    t_in_item     r_item, n_item;
    t_op          r_op, n_op;
    logic [3:0]   r_q, n_q;
    logic [7:0]   r_bottom, n_bottom;
    logic [5:0]   r_frac, n_frac;
    logic [2:0]   r_sector, n_sector;
    logic [7:0]   r_span, n_span;
    logic [13:0]  r_pr, n_pr;
    logic [13:0]  r_pf, n_pf;

    logic         led_ok;
    logic         accept;
    logic [18:0]  mul_hue;
    logic [15:0]  mul_bottom;
    logic [9:0]   sixty_q;
    logic [9:0]   frac_w;
    logic [28:0]  mul_rise;
    logic [28:0]  mul_fall;
    logic [7:0]   rising;
    logic [7:0]   falling;

    // A word is taken only while idle and after the duty store is cleared.
    assign o_stall = (r_state != F_IDLE) || i_clearing;
    assign accept  = i_valid && !o_stall;
    assign led_ok  = 32'(i_item.led_index) < NUM_LEDS;
    assign o_op    = r_op;

    // Arithmetic of the HSV steps, each from registered operands.
    always_comb begin
        mul_hue    = 19'(r_item.hue) * 19'(HUE_RECIP);
        mul_bottom = 16'(FULL_SCALE - r_item.saturation) * 16'(r_item.brightness);
        sixty_q    = 10'({r_q, 6'b0}) - 10'({r_q, 2'b0});
        frac_w     = 10'(r_item.hue) - sixty_q;
        mul_rise   = 29'(r_pr) * 29'(DIV60_RECIP);
        mul_fall   = 29'(r_pf) * 29'(DIV60_RECIP);
        rising     = mul_rise[27:20] + r_bottom;
        falling    = mul_fall[27:20] + r_bottom;
    end

    // Sequencer for classification and the HSV steps.
    always_comb begin
        n_state  = r_state;
        n_item   = r_item;
        n_op     = r_op;
        n_q      = r_q;
        n_bottom = r_bottom;
        n_frac   = r_frac;
        n_sector = r_sector;
        n_span   = r_span;
        n_pr     = r_pr;
        n_pf     = r_pf;
        o_push   = 1'b0;
        case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_item = i_item;
                    case (i_item.kind)
                        KIND_RGB: begin
                            if (led_ok) begin
                                n_op.is_tick = 1'b0;
                                n_op.led     = i_item.led_index;
                                n_op.red     = i_item.red;
                                n_op.green   = i_item.green;
                                n_op.blue    = i_item.blue;
                                n_state      = F_PUSH;
                            end
                        end
                        KIND_HSV: begin
                            if (led_ok) begin
                                n_state = F_MUL1;
                            end
                        end
                        KIND_TICK: begin
                            n_op.is_tick = 1'b1;
                            n_state      = F_PUSH;
                        end
                        default: begin
                            n_state = F_IDLE;
                        end
                    endcase
                end
            end
            F_MUL1: begin
                n_q      = mul_hue[18:15];
                n_bottom = mul_bottom[15:8];
                n_state  = F_FRAC;
            end
            F_FRAC: begin
                n_frac   = frac_w[5:0];
                n_sector = (r_q > 4'(LAST_SECTOR)) ? 3'(LAST_SECTOR) : r_q[2:0];
                n_span   = r_item.brightness - r_bottom;
                n_state  = F_MUL2;
            end
            F_MUL2: begin
                n_pr    = 14'(r_span) * 14'(r_frac);
                n_pf    = 14'(r_span) * 14'(6'(SECTOR_DEG) - r_frac);
                n_state = F_DIV;
            end
            F_DIV: begin
                n_op.is_tick = 1'b0;
                n_op.led     = r_item.led_index;
                // Pick the channel order for the hue sector.
                case (r_sector)
                    3'd0: begin
                        n_op.red = r_item.brightness; n_op.green = rising;
                        n_op.blue = r_bottom;
                    end
                    3'd1: begin
                        n_op.red = falling; n_op.green = r_item.brightness;
                        n_op.blue = r_bottom;
                    end
                    3'd2: begin
                        n_op.red = r_bottom; n_op.green = r_item.brightness;
                        n_op.blue = rising;
                    end
                    3'd3: begin
                        n_op.red = r_bottom; n_op.green = falling;
                        n_op.blue = r_item.brightness;
                    end
                    3'd4: begin
                        n_op.red = rising; n_op.green = r_bottom;
                        n_op.blue = r_item.brightness;
                    end
                    default: begin
                        n_op.red = r_item.brightness; n_op.green = r_bottom;
                        n_op.blue = falling;
                    end
                endcase
                n_state = F_PUSH;
            end
            F_PUSH: begin
                o_push = 1'b1;
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_op     <= n_op;
        r_q      <= n_q;
        r_bottom <= n_bottom;
        r_frac   <= n_frac;
        r_sector <= n_sector;
        r_span   <= n_span;
        r_pr     <= n_pr;
        r_pf     <= n_pf;
    end

endmodule

// File: rtl/core/lpsfg_queue.sv
// Short queue of classified operations between the front and the back.
// Depends on lpsfg_pkg.
module lpsfg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lpsfg_pkg::t_op i_op,
    input  logic           i_pop,
    output lpsfg_pkg::t_op o_head,
    output logic           o_full,
    output logic           o_empty
);
    import lpsfg_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_op              r_buf [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_buf[r_rptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wptr] <= i_op;
        end
    end

endmodule

// File: rtl/core/lpsfg_back.sv
// Back end: duty store in eight byte-lane banks, PWM counter, and the
// byte stream with its output register. Depends on lpsfg_pkg.
module lpsfg_back #(
    parameter int NUM_LEDS = lpsfg_pkg::NUM_LEDS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lpsfg_pkg::t_op       i_op,
    input  logic                 i_empty,
    output logic                 o_pop,
    input  logic [7:0]           i_pwm_max,
    output logic                 o_clearing,
    output logic                 o_valid,
    output lpsfg_pkg::t_out_word o_word,
    input  logic                 i_stall
);
    import lpsfg_pkg::*;

    localparam int CHANNELS    = 3 * NUM_LEDS;
    localparam int ROWS        = (CHANNELS + BYTE_BITS - 1) / BYTE_BITS;
    localparam int FRAME_BYTES = CHANNELS / BYTE_BITS;
    localparam int ROW_W       = $clog2(ROWS);

    typedef enum logic [2:0] {
        B_CLEAR  = 3'b001,
        B_IDLE   = 3'b010,
        B_STREAM = 3'b100
    } t_back_state;

    t_back_state      r_state, n_state;
    logic [ROW_W-1:0] r_row, n_row;
    logic [7:0]       r_cnt, n_cnt;
    logic             r_pend, n_pend;
    logic             r_last_pend, n_last_pend;
    logic             r_out_valid, n_out_valid;
    t_out_word        r_out_word, n_out_word;
    logic [7:0]       r_mem [BYTE_BITS][ROWS];
    logic [7:0]       r_rd [BYTE_BITS];

    logic             do_write;
    logic             issue;
    logic             last_row;
    logic [5:0]       ch [3];
    logic [7:0]       duty [3];
    logic             we [BYTE_BITS];
    logic [ROW_W-1:0] waddr [BYTE_BITS];
    logic [7:0]       wdata [BYTE_BITS];
    logic [7:0]       frame_byte;

    assign o_clearing = r_state == B_CLEAR;
    assign o_pop      = (r_state == B_IDLE) && !i_empty;
    assign do_write   = o_pop && !i_op.is_tick;
    assign last_row   = r_row == ROW_W'(FRAME_BYTES - 1);
    // A row read starts only when its byte can land in the output register.
    assign issue      = (r_state == B_STREAM) && !r_pend && (!r_out_valid || !i_stall);
    assign o_valid    = r_out_valid;
    assign o_word     = r_out_word;

    // Bank write ports: the clear pass, or the three channels of one LED.
    always_comb begin
        ch[0]   = 6'({i_op.led, 1'b0}) + 6'(i_op.led);
        ch[1]   = ch[0] + 6'd1;
        ch[2]   = ch[0] + 6'd2;
        duty[0] = i_op.red;
        duty[1] = i_op.green;
        duty[2] = i_op.blue;
        for (int b = 0; b < BYTE_BITS; b++) begin
            we[b]    = 1'b0;
            waddr[b] = '0;
            wdata[b] = '0;
            if (r_state == B_CLEAR) begin
                we[b]    = 1'b1;
                waddr[b] = r_row;
            end else if (do_write) begin
                for (int k = 0; k < 3; k++) begin
                    if (ch[k][2:0] == 3'(b)) begin
                        we[b]    = 1'b1;
                        waddr[b] = ROW_W'(ch[k][5:3]);
                        wdata[b] = duty[k];
                    end
                end
            end
        end
    end

    // Channel bits of the row just read.
    always_comb begin
        for (int b = 0; b < BYTE_BITS; b++) begin
            frame_byte[b] = r_cnt >= r_rd[b];
        end
    end

    // Sequencer: clear pass, operation dispatch and row streaming.
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_cnt       = r_cnt;
        n_pend      = 1'b0;
        n_last_pend = r_last_pend;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        case (r_state)
            B_CLEAR: begin
                if (r_row == ROW_W'(ROWS - 1)) begin
                    n_row   = '0;
                    n_state = B_IDLE;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
            B_IDLE: begin
                if (o_pop && i_op.is_tick) begin
                    n_cnt   = ((r_cnt >= i_pwm_max) ? 8'd0 : r_cnt) + 8'd1;
                    n_row   = '0;
                    n_state = B_STREAM;
                end
            end
            B_STREAM: begin
                if (issue) begin
                    n_pend      = 1'b1;
                    n_last_pend = last_row;
                    if (last_row) begin
                        n_row   = '0;
                        n_state = B_IDLE;
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
        // Output register: drains on a taken word, loads the byte just read.
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        if (r_pend) begin
            n_out_valid           = 1'b1;
            n_out_word.shift_byte = frame_byte;
            n_out_word.latch_last = r_last_pend;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_row       <= '0;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_last_pend <= n_last_pend;
        r_out_word  <= n_out_word;
    end

    // Duty store banks: one write and one registered read per bank.
    always_ff @(posedge i_clk) begin
        for (int b = 0; b < BYTE_BITS; b++) begin
            if (we[b]) begin
                r_mem[b][waddr[b]] <= wdata[b];
            end
            if (issue) begin
                r_rd[b] <= r_mem[b][r_row];
            end
        end
    end

endmodule

// File: tb/led_pwm_shift_frame_generator_test.sv
`timescale 1ns / 100ps

// Self-checking testbench for the LED PWM shift-frame generator: directed and random words,
// pwm_max settings and output back-pressure, each output word compared with a local model.
// Depends on lpsfg_pkg and the led_pwm_shift_frame_generator RTL.
module led_pwm_shift_frame_generator_test;
    import lpsfg_pkg::*;

    localparam int NUM_LEDS     = NUM_LEDS_DEF;
    localparam int NUM_CHANNELS = NUM_LEDS * 3;
    localparam int FRAME_BYTES  = NUM_CHANNELS / BYTE_BITS;

    localparam logic [1:0]         KIND_UNUSED  = 2'd3;
    localparam logic [PADDR_W-1:0] PWM_MAX_ADDR = PADDR_W'(4 * int'(REG_PWM_MAX));

    localparam int SETTLE_CYCLES    = 24;
    localparam int LONG_HOLD        = 160;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int RANDOM_PER_PHASE = 100;

    // Block ports.
    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    t_in_item           i_item  = '0;
    logic               o_stall;
    logic               o_valid;
    t_out_word          o_word;
    logic               i_stall = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;

    // Local copy of the block's state and configuration.
    logic [7:0] duty_mirror [NUM_CHANNELS] = '{default: 8'd0};
    logic [7:0] counter_mirror = 8'd0;
    logic [7:0] pwm_max_mirror = PWM_MAX_RESET;

    // Output words still owed by the block, oldest first.
    t_out_word  pending_bytes [$];

    int fail_count     = 0;
    int items_sent     = 0;
    int ticks_sent     = 0;
    int bytes_checked  = 0;
    int config_writes  = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_req       = 0;
    int hold_ack       = 0;
    int hold_left      = 0;
    int idle_cycles    = 0;

    led_pwm_shift_frame_generator #(
        .NUM_LEDS(NUM_LEDS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_word  (o_word),
        .i_stall (i_stall),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 i_clk = ~i_clk;

    // Store three duties for one LED; LEDs past the end are dropped.
    function automatic void store_led_duties(input logic [3:0] led, input int unsigned r,
                                             input int unsigned g, input int unsigned b);
        int base;
        if (int'(led) < NUM_LEDS) begin
            base = int'(led) * 3;
            duty_mirror[base]     = r[7:0];
            duty_mirror[base + 1] = g[7:0];
            duty_mirror[base + 2] = b[7:0];
        end
    endfunction

    // Apply one accepted word to the local state and queue the bytes a tick produces.
    function automatic void predict_frame(input t_in_item item);
        int unsigned sector, frac, top, bottom, span, rising, falling;
        int unsigned r, g, b;
        int          byte_idx, bit_idx;
        t_out_word   word;
        case (item.kind)
            KIND_RGB: begin
                store_led_duties(item.led_index, item.red, item.green, item.blue);
            end
            KIND_HSV: begin
                sector  = item.hue / SECTOR_DEG;
                frac    = item.hue % SECTOR_DEG;
                top     = item.brightness;
                bottom  = ((FULL_SCALE - item.saturation) * item.brightness) >> 8;
                span    = top - bottom;
                rising  = (span * frac) / SECTOR_DEG + bottom;
                falling = (span * (SECTOR_DEG - frac)) / SECTOR_DEG + bottom;
                // Hues of 360 and above land in the last sector.
                case (sector)
                    0: begin r = top;     g = rising;  b = bottom;  end
                    1: begin r = falling; g = top;     b = bottom;  end
                    2: begin r = bottom;  g = top;     b = rising;  end
                    3: begin r = bottom;  g = falling; b = top;     end
                    4: begin r = rising;  g = bottom;  b = top;     end
                    default: begin r = top; g = bottom; b = falling; end
                endcase
                store_led_duties(item.led_index, r, g, b);
            end
            KIND_TICK: begin
                // Wrap first, then step; a pwm_max of zero always wraps.
                if (counter_mirror >= pwm_max_mirror)
                    counter_mirror = 8'd0;
                counter_mirror = counter_mirror + 8'd1;
                for (byte_idx = 0; byte_idx < FRAME_BYTES; byte_idx++) begin
                    for (bit_idx = 0; bit_idx < BYTE_BITS; bit_idx++)
                        word.shift_byte[bit_idx] =
                            counter_mirror >= duty_mirror[byte_idx * BYTE_BITS + bit_idx];
                    word.latch_last = (byte_idx == FRAME_BYTES - 1);
                    pending_bytes.push_back(word);
                end
                ticks_sent++;
            end
            default: begin
                // The unused kind changes nothing.
            end
        endcase
    endfunction

    function automatic t_in_item make_item(input logic [1:0] kind, input logic [3:0] led,
                                           input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b, input logic [8:0] hue,
                                           input logic [7:0] sat, input logic [7:0] bright);
        t_in_item item;
        item.kind       = kind;
        item.led_index  = led;
        item.red        = r;
        item.green      = g;
        item.blue       = b;
        item.hue        = hue;
        item.saturation = sat;
        item.brightness = bright;
        return item;
    endfunction

    // Duties are biased toward the counter's range so both bit values show up.
    function automatic logic [7:0] random_duty();
        if ($urandom_range(1) == 0)
            return 8'($urandom_range(0, pwm_max_mirror));
        return 8'($urandom);
    endfunction

    function automatic t_in_item random_item();
        t_in_item    item;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40)
            item.kind = KIND_TICK;
        else if (pick < 70)
            item.kind = KIND_RGB;
        else if (pick < 95)
            item.kind = KIND_HSV;
        else
            item.kind = KIND_UNUSED;
        item.led_index  = 4'($urandom);
        item.red        = random_duty();
        item.green      = random_duty();
        item.blue       = random_duty();
        item.hue        = ($urandom_range(4) == 0) ? 9'($urandom) : 9'($urandom_range(0, 359));
        item.saturation = 8'($urandom);
        item.brightness = 8'($urandom);
        return item;
    endfunction

    // Offer one word, after a random gap, and hold it until the block takes it.
    task automatic send_item(input t_in_item item);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= item;
        @(posedge i_clk);
        while (o_stall !== 1'b0)
            @(posedge i_clk);
        predict_frame(item);
        items_sent++;
    endtask

    // Stop sending and wait until every owed word is out and the block is quiet.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_bytes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write pwm_max over APB and read it back.
    task automatic write_pwm_max(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PWM_MAX_ADDR;
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        pwm_max_mirror = value;
        config_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (prdata[7:0] !== value) begin
            $error("pwm_max readback: expected %0d, actual %0d", value, prdata[7:0]);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Frames right after reset, RGB extremes, every HSV sector and hues past 359.
    task automatic test_directed_items();
        send_item(make_item(KIND_TICK, 4'd0, 8'd0, 8'd0, 8'd0, 9'd0, 8'd0, 8'd0));
        send_item(make_item(KIND_RGB, 4'd0, 8'd255, 8'd255, 8'd255, 9'd0, 8'd0, 8'd0));
        send_item(make_item(KIND_RGB, 4'd15, 8'd1, 8'd254, 8'd0, 9'd511, 8'd255, 8'd255));
        send_item(make_item(KIND_RGB, 4'd7, 8'd128, 8'd127, 8'd2, 9'd0, 8'd0, 8'd0));
        send_item(make_item(KIND_UNUSED, 4'd0, 8'd0, 8'd0, 8'd0, 9'd100, 8'd9, 8'd9));
        send_item(make_item(KIND_TICK, 4'd15, 8'd255, 8'd255, 8'd255, 9'd511, 8'd255, 8'd255));
        send_item(make_item(KIND_HSV, 4'd1, 8'd0, 8'd0, 8'd0, 9'd0, 8'd255, 8'd255));
        send_item(make_item(KIND_HSV, 4'd2, 8'd0, 8'd0, 8'd0, 9'd59, 8'd255, 8'd200));
        send_item(make_item(KIND_HSV, 4'd3, 8'd0, 8'd0, 8'd0, 9'd60, 8'd128, 8'd255));
        send_item(make_item(KIND_HSV, 4'd11, 8'd0, 8'd0, 8'd0, 9'd120, 8'd77, 8'd180));
        send_item(make_item(KIND_HSV, 4'd4, 8'd0, 8'd0, 8'd0, 9'd180, 8'd0, 8'd255));
        send_item(make_item(KIND_HSV, 4'd12, 8'd0, 8'd0, 8'd0, 9'd200, 8'd240, 8'd3));
        send_item(make_item(KIND_HSV, 4'd5, 8'd0, 8'd0, 8'd0, 9'd240, 8'd255, 8'd0));
        send_item(make_item(KIND_HSV, 4'd13, 8'd0, 8'd0, 8'd0, 9'd270, 8'd100, 8'd100));
        send_item(make_item(KIND_HSV, 4'd6, 8'd0, 8'd0, 8'd0, 9'd300, 8'd200, 8'd255));
        send_item(make_item(KIND_HSV, 4'd8, 8'd0, 8'd0, 8'd0, 9'd359, 8'd255, 8'd255));
        send_item(make_item(KIND_HSV, 4'd9, 8'd0, 8'd0, 8'd0, 9'd360, 8'd255, 8'd255));
        send_item(make_item(KIND_HSV, 4'd10, 8'd0, 8'd0, 8'd0, 9'd511, 8'd1, 8'd1));
        repeat (3)
            send_item(make_item(KIND_TICK, 4'd0, 8'd0, 8'd0, 8'd0, 9'd0, 8'd0, 8'd0));
    endtask

    // Counter behavior at the pwm_max extremes, zero included.
    task automatic test_pwm_max_extremes();
        int         k;
        logic [7:0] value;
        t_in_item   item;
        for (k = 0; k < 5; k++) begin
            case (k)
                0: value = 8'd1;
                1: value = 8'd0;
                2: value = 8'd2;
                3: value = 8'($urandom_range(3, 254));
                default: value = 8'd255;
            endcase
            wait_drained();
            write_pwm_max(value);
            send_item(make_item(KIND_RGB, 4'($urandom), 8'd1, 8'd2, value, 9'd0, 8'd0, 8'd0));
            repeat (4) begin
                item      = random_item();
                item.kind = KIND_TICK;
                send_item(item);
            end
        end
    endtask

    // Random traffic in three idling phases, each with its own pwm_max.
    task automatic test_random_traffic();
        int phase;
        for (phase = 0; phase < 3; phase++) begin
            wait_drained();
            case (phase)
                0: begin
                    send_idle_pct = 15;
                    recv_idle_pct = 53;
                    write_pwm_max(8'($urandom_range(1, 24)));
                end
                1: begin
                    send_idle_pct = 53;
                    recv_idle_pct = 15;
                    write_pwm_max(8'($urandom_range(25, 254)));
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    write_pwm_max(8'($urandom_range(1, 255)));
                end
            endcase
            repeat (RANDOM_PER_PHASE)
                send_item(random_item());
        end
    endtask

    // The receiver holds off for a long stretch while ticks keep coming, then the
    // sender pauses until everything owed has arrived.
    task automatic test_output_hold();
        t_in_item item;
        hold_req <= hold_req + 1;
        repeat (12) begin
            item = random_item();
            if ($urandom_range(3) != 0)
                item.kind = KIND_TICK;
            send_item(item);
        end
        wait_drained();
    endtask

    // Compare each taken output word with the oldest expected one, then pick the
    // next stall value: a requested long hold first, else random idling.
    always @(posedge i_clk) begin : check_words
        t_out_word want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (pending_bytes.size() == 0) begin
                $error("unexpected word: shift_byte %02h latch_last %0b",
                       o_word.shift_byte, o_word.latch_last);
                fail_count++;
            end else begin
                want = pending_bytes.pop_front();
                bytes_checked++;
                if (o_word.shift_byte !== want.shift_byte) begin
                    $error("shift_byte: expected %02h, actual %02h",
                           want.shift_byte, o_word.shift_byte);
                    fail_count++;
                end
                if (o_word.latch_last !== want.latch_last) begin
                    $error("latch_last: expected %0b, actual %0b",
                           want.latch_last, o_word.latch_last);
                    fail_count++;
                end
            end
        end
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            i_stall   <= 1'b1;
            hold_left <= LONG_HOLD - 1;
            hold_ack  <= hold_req;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: end the run when no word moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $error("no word moved for %0d cycles, %0d words still owed",
                   idle_cycles, pending_bytes.size());
            $display("led_pwm_shift_frame_generator test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Reset once, run the tests in turn, then report.
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 15;
        recv_idle_pct = 53;
        test_directed_items();
        test_pwm_max_extremes();
        test_random_traffic();
        test_output_hold();
        wait_drained();
        $display("Covered %0d input words (%0d ticks) and %0d pwm_max writes.",
                 items_sent, ticks_sent, config_writes);
        $display("Checked %0d output words under three idling mixes and one long hold.",
                 bytes_checked);
        if (fail_count == 0 && pending_bytes.size() == 0)
            $display("led_pwm_shift_frame_generator test passed");
        else
            $display("led_pwm_shift_frame_generator test failed");
        $finish;
    end

endmodule
